FILE: rtl/running_window_median_defines.svh
// ----------------------------------------------------------------------------
// running window median assertion macros
// shared concurrent assertion shorthands, clocked on clk, off during rst_n low
// ----------------------------------------------------------------------------
`ifndef RUNNING_WINDOW_MEDIAN_DEFINES_SVH
`define RUNNING_WINDOW_MEDIAN_DEFINES_SVH

// same-cycle implication
`define RWM_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("running_window_median: same-cycle check failed");

// next-cycle implication
`define RWM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("running_window_median: next-cycle check failed");

`endif

FILE: rtl/rwm_pkg.sv
// ----------------------------------------------------------------------------
// rwm_pkg
// sizes and cell link type for the running window median filter
// ----------------------------------------------------------------------------
package rwm_pkg;

    localparam int WINDOW      = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int VALUE_BITS  = 16;
    localparam int MEDIAN_BITS = 17;
    localparam int COUNT_BITS  = 4;
    localparam int AGE_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int IDX_W       = AGE_W;
    localparam int FILL_W      = $clog2(WINDOW + 1);

    // state of one cell as seen by its neighbors
    typedef struct packed {
        logic                   occ;
        logic                   gt;
        logic [AGE_W-1:0]       age;
        logic [SAMPLE_BITS-1:0] value;
    } cell_link_t;

endpackage

FILE: rtl/rwm_in_if.sv
// ----------------------------------------------------------------------------
// rwm_in_if
// sample channel: one reading and its good flag per transaction
// ----------------------------------------------------------------------------
interface rwm_in_if;
    import rwm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] sample_value;
    logic                  sample_valid;

    modport source (output valid, output sample_value, output sample_valid, input ready);
    modport sink   (input valid, input sample_value, input sample_valid, output ready);
endinterface

FILE: rtl/rwm_out_if.sv
// ----------------------------------------------------------------------------
// rwm_out_if
// result channel: doubled median and window fill per transaction
// ----------------------------------------------------------------------------
interface rwm_out_if;
    import rwm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [MEDIAN_BITS-1:0] median_twice;
    logic [COUNT_BITS-1:0]  count_held;

    modport source (output valid, output median_twice, output count_held, input ready);
    modport sink   (input valid, input median_twice, input count_held, output ready);
endinterface

FILE: rtl/running_window_median.sv
// ----------------------------------------------------------------------------
// running_window_median
// moving median over the last WINDOW samples, result as twice the median
// ----------------------------------------------------------------------------
// channel   dir  payload                         transaction
// samples   in   sample_value, sample_valid      valid && ready
// medians   out  median_twice, count_held        valid && ready
//
// one sample per cycle sustained while results are taken; its result passes
// through the cell row registers, then the taps, into the output register
// reset empties the window; no clearing pass, samples are taken right away
// a stalled result holds the next sample back once one more has been taken
// ----------------------------------------------------------------------------
`include "running_window_median_defines.svh"

module running_window_median (
    input  logic     clk,
    input  logic     rst_n,
    rwm_in_if.sink   samples,
    rwm_out_if.source medians
);
    import rwm_pkg::*;

    logic                   pend_reg;
    logic                   pend_next;
    logic [FILL_W-1:0]      fill_reg;
    logic [FILL_W-1:0]      fill_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [MEDIAN_BITS-1:0] median_reg;
    logic [COUNT_BITS-1:0]  count_reg;
    logic                   in_take;
    logic                   out_free;
    logic                   out_load;
    logic                   full;
    logic [SAMPLE_BITS-1:0] new_value;
    logic [FILL_W-1:0]      fill_less;
    logic [IDX_W-1:0]       lo_idx;
    logic [IDX_W-1:0]       hi_idx;
    logic [SAMPLE_BITS-1:0] lo_value;
    logic [SAMPLE_BITS-1:0] hi_value;

    assign out_free      = !out_valid_reg || medians.ready;
    assign out_load      = pend_reg && out_free;
    assign samples.ready = !pend_reg || out_free;
    assign in_take       = samples.valid && samples.ready;

    assign full      = (fill_reg == FILL_W'(WINDOW));
    assign new_value = samples.sample_valid ? samples.sample_value[SAMPLE_BITS-1:0] : '0;
    assign fill_next = full ? fill_reg : fill_reg + FILL_W'(1);

    // middle pair of the sorted window, one cell twice for an odd fill
    assign fill_less = fill_reg - FILL_W'(1);
    assign lo_idx    = IDX_W'(fill_less >> 1);
    assign hi_idx    = IDX_W'(fill_reg >> 1);

    rwm_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_take),
        .full      (full),
        .new_value (new_value),
        .lo_idx    (lo_idx),
        .hi_idx    (hi_idx),
        .lo_value  (lo_value),
        .hi_value  (hi_value)
    );

    always_comb
    begin
        pend_next = pend_reg;
        if (in_take)
        begin
            pend_next = 1'b1;
        end
        else if (out_load)
        begin
            pend_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (medians.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (in_take)
            begin
                fill_reg <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            median_reg <= MEDIAN_BITS'(lo_value) + MEDIAN_BITS'(hi_value);
            count_reg  <= COUNT_BITS'(fill_reg);
        end
    end

    assign medians.valid        = out_valid_reg;
    assign medians.median_twice = median_reg;
    assign medians.count_held   = count_reg;

    `RWM_ASSERT_NEXT(a_take_pends, in_take, pend_reg && (fill_reg != '0))
    `RWM_ASSERT_SAME(a_stall_blocks, pend_reg && !out_free, !samples.ready)
    `RWM_ASSERT_SAME(a_fill_range, 1'b1, fill_reg <= FILL_W'(WINDOW))
    `RWM_ASSERT_NEXT(a_load_shows, out_load, medians.valid && (medians.count_held != '0))
endmodule

FILE: rtl/rwm_cell.sv
// ----------------------------------------------------------------------------
// rwm_cell
// one slot of the sorted window: drops the oldest entry, inserts the new one
// ----------------------------------------------------------------------------
module rwm_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  logic                            full,
    input  logic [rwm_pkg::IDX_W-1:0]       cell_index,
    input  logic [rwm_pkg::SAMPLE_BITS-1:0] new_value,
    input  logic [rwm_pkg::IDX_W-1:0]       lo_idx,
    input  logic [rwm_pkg::IDX_W-1:0]       hi_idx,
    input  rwm_pkg::cell_link_t             left_link,
    input  rwm_pkg::cell_link_t             right_link,
    input  logic                            shift_in,
    output rwm_pkg::cell_link_t             self_link,
    output logic                            shift_out,
    output logic [rwm_pkg::SAMPLE_BITS-1:0] tap_lo,
    output logic [rwm_pkg::SAMPLE_BITS-1:0] tap_hi
);
    import rwm_pkg::*;

    logic                   occ_reg;
    logic                   occ_next;
    logic [AGE_W-1:0]       age_reg;
    logic [AGE_W-1:0]       age_next;
    logic [SAMPLE_BITS-1:0] value_reg;
    logic [SAMPLE_BITS-1:0] value_next;
    logic                   del_self;
    cell_link_t             cur;
    cell_link_t             prv;

    // an empty cell counts as greater than any sample
    assign self_link.occ   = occ_reg;
    assign self_link.gt    = !occ_reg || (value_reg > new_value);
    assign self_link.age   = age_reg;
    assign self_link.value = value_reg;

    assign del_self  = full && occ_reg && (age_reg == AGE_W'(WINDOW - 1));
    assign shift_out = shift_in || del_self;

    // slot contents after removing the oldest entry
    assign cur = shift_out ? right_link : self_link;
    assign prv = shift_in ? self_link : left_link;

    always_comb
    begin
        if (!cur.gt)
        begin
            occ_next   = cur.occ;
            age_next   = cur.age + AGE_W'(1);
            value_next = cur.value;
        end
        else if (!prv.gt)
        begin
            occ_next   = 1'b1;
            age_next   = '0;
            value_next = new_value;
        end
        else
        begin
            occ_next   = prv.occ;
            age_next   = prv.age + AGE_W'(1);
            value_next = prv.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else if (load)
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            age_reg   <= age_next;
            value_reg <= value_next;
        end
    end

    assign tap_lo = (cell_index == lo_idx) ? value_reg : '0;
    assign tap_hi = (cell_index == hi_idx) ? value_reg : '0;
endmodule

FILE: rtl/rwm_chain.sv
// ----------------------------------------------------------------------------
// rwm_chain
// row of window cells kept in ascending order, with the middle-pair taps
// ----------------------------------------------------------------------------
module rwm_chain (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  logic                            full,
    input  logic [rwm_pkg::SAMPLE_BITS-1:0] new_value,
    input  logic [rwm_pkg::IDX_W-1:0]       lo_idx,
    input  logic [rwm_pkg::IDX_W-1:0]       hi_idx,
    output logic [rwm_pkg::SAMPLE_BITS-1:0] lo_value,
    output logic [rwm_pkg::SAMPLE_BITS-1:0] hi_value
);
    import rwm_pkg::*;

    cell_link_t             links [WINDOW];
    logic                   shift [WINDOW+1];
    logic [SAMPLE_BITS-1:0] taps_lo [WINDOW];
    logic [SAMPLE_BITS-1:0] taps_hi [WINDOW];
    cell_link_t             edge_lo;
    cell_link_t             edge_hi;

    // below the first cell everything is smaller, past the last cell it is empty
    assign edge_lo  = '{occ: 1'b0, gt: 1'b0, age: '0, value: '0};
    assign edge_hi  = '{occ: 1'b0, gt: 1'b1, age: '0, value: '0};
    assign shift[0] = 1'b0;

    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        rwm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .load       (load),
            .full       (full),
            .cell_index (IDX_W'(i)),
            .new_value  (new_value),
            .lo_idx     (lo_idx),
            .hi_idx     (hi_idx),
            .left_link  ((i == 0) ? edge_lo : links[(i == 0) ? 0 : i - 1]),
            .right_link ((i == WINDOW - 1) ? edge_hi : links[(i == WINDOW - 1) ? i : i + 1]),
            .shift_in   (shift[i]),
            .self_link  (links[i]),
            .shift_out  (shift[i+1]),
            .tap_lo     (taps_lo[i]),
            .tap_hi     (taps_hi[i])
        );
    end

    always_comb
    begin
        lo_value = '0;
        hi_value = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            lo_value = lo_value | taps_lo[i];
            hi_value = hi_value | taps_hi[i];
        end
    end
endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// running_window_median testbench
// drives readings with random gaps and stalls, predicts the doubled median of
// the last eight readings and checks every result transaction in order
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rwm_pkg::*;

    typedef struct packed {
        logic [MEDIAN_BITS-1:0] median_twice;
        logic [COUNT_BITS-1:0]  count_held;
    } median_result_t;

    // ring of recent readings in arrival order, plus the medians still owed
    class window_median_model;
        logic [SAMPLE_BITS-1:0] ring [WINDOW];
        int unsigned            next_slot;
        int unsigned            held;
        int unsigned            mismatches;
        median_result_t         pending_medians [$];

        function new();
            next_slot  = 0;
            held       = 0;
            mismatches = 0;
        endfunction

        function void take_sample(logic [VALUE_BITS-1:0] value, logic good);
            logic [SAMPLE_BITS-1:0] sorted [WINDOW];
            logic [SAMPLE_BITS-1:0] key;
            median_result_t         res;
            int                     i;
            int                     j;
            ring[next_slot] = good ? value[SAMPLE_BITS-1:0] : '0;
            next_slot = (next_slot + 1) % WINDOW;
            if (held < WINDOW)
                held++;
            // only the slots written so far take part while the ring fills
            for (i = 0; i < held; i++)
                sorted[i] = ring[i];
            for (i = 1; i < held; i++)
            begin
                key = sorted[i];
                j = i;
                while (j > 0 && sorted[j-1] > key)
                begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = key;
            end
            if (held % 2 == 0)
                res.median_twice = MEDIAN_BITS'(sorted[held/2-1]) + MEDIAN_BITS'(sorted[held/2]);
            else
                res.median_twice = MEDIAN_BITS'(sorted[held/2]) << 1;
            res.count_held = COUNT_BITS'(held);
            pending_medians.push_back(res);
        endfunction

        function void compare_median(logic [MEDIAN_BITS-1:0] median, logic [COUNT_BITS-1:0] count);
            median_result_t want;
            if (pending_medians.size() == 0)
            begin
                $error("median transaction with nothing pending: median_twice %0d count_held %0d",
                       median, count);
                mismatches++;
                return;
            end
            want = pending_medians.pop_front();
            if (median !== want.median_twice)
            begin
                $error("median_twice: expected %0d, actual %0d", want.median_twice, median);
                mismatches++;
            end
            if (count !== want.count_held)
            begin
                $error("count_held: expected %0d, actual %0d", want.count_held, count);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   idle_on;

    rwm_in_if  samples ();
    rwm_out_if medians ();

    window_median_model model = new();

    running_window_median dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples.sink),
        .medians (medians.source)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // valid stays high from one transaction to the next when there is no gap
    task automatic send_sample(input logic [VALUE_BITS-1:0] value, input logic good);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            samples.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples.valid        <= 1'b1;
        samples.sample_value <= value;
        samples.sample_valid <= good;
        do
            @(posedge clk);
        while (!samples.ready);
        model.take_sample(value, good);
    endtask

    task automatic drain_medians();
        samples.valid <= 1'b0;
        while (model.pending_medians.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic send_random_sample();
        logic [VALUE_BITS-1:0] value;
        int                    r;
        r = $urandom_range(0, 99);
        if (r < 40)
            value = VALUE_BITS'($urandom);
        else if (r < 65)
            value = VALUE_BITS'($urandom_range(0, 7));          // many ties
        else if (r < 75)
            value = $urandom_range(0, 1) ? '1 : '0;
        else if (r < 90)
            value = VALUE_BITS'($urandom_range(32760, 32775));
        else
            value = VALUE_BITS'($urandom_range(65520, 65535));
        send_sample(value, $urandom_range(0, 99) >= 12);
    endtask

    // result side back-pressure
    initial
    begin
        int hold;
        int n;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                medians.ready <= 1'b0;
                hold--;
            end
            else
            begin
                n = pick_gap();
                medians.ready <= (n == 0);
                hold = (n > 0) ? n - 1 : 0;
            end
        end
    end

    always @(posedge clk)
        if (rst_n && medians.valid && medians.ready)
            model.compare_median(medians.median_twice, medians.count_held);

    initial
    begin
        int k;
        samples.valid        <= 1'b0;
        samples.sample_value <= '0;
        samples.sample_valid <= 1'b0;
        medians.ready        <= 1'b0;
        rst_n                <= 1'b0;
        idle_on = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // fill the window one by one, back to back
        send_sample(16'h0000, 1'b1);
        send_sample(16'hffff, 1'b1);
        send_sample(16'hffff, 1'b0);    // bad reading counts as zero
        send_sample(16'haaaa, 1'b1);
        send_sample(16'h5555, 1'b1);
        send_sample(16'h0001, 1'b1);
        send_sample(16'hfffe, 1'b1);
        send_sample(16'h8000, 1'b1);
        // full window: oldest slot overwritten, then ring wrap
        send_sample(16'hffff, 1'b1);
        send_sample(16'hffff, 1'b1);
        send_sample(16'hffff, 1'b1);
        send_sample(16'hffff, 1'b1);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h1234, 1'b1);
        send_sample(16'h1234, 1'b1);
        send_sample(16'h1234, 1'b1);
        idle_on = 1'b1;
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hffff, 1'b1);
        send_sample(16'hffff, 1'b1);
        send_sample(16'hffff, 1'b1);
        send_sample(16'hffff, 1'b1);
        drain_medians();

        for (k = 0; k < 850; k++)
        begin
            // alternate stretches with and without idling
            if (k % 100 == 0)
                idle_on = (k / 100) % 3 != 1;
            if (k == 430)
                drain_medians();
            send_random_sample();
        end

        samples.valid <= 1'b0;
        while (model.pending_medians.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (model.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
